FILE: rtl/clx_pkg.sv
// shared types, character constants and character class helpers for the source lexer
package clx_pkg;

  typedef logic [4:0] tok_type_t;

  localparam tok_type_t TOK_EOF       = 5'd0;
  localparam tok_type_t TOK_IDENT     = 5'd1;
  localparam tok_type_t TOK_NUMBER    = 5'd2;
  localparam tok_type_t TOK_PATH      = 5'd3;
  localparam tok_type_t TOK_STRING    = 5'd4;
  localparam tok_type_t TOK_POUND     = 5'd5;
  localparam tok_type_t TOK_LPAREN    = 5'd6;
  localparam tok_type_t TOK_RPAREN    = 5'd7;
  localparam tok_type_t TOK_LBRACE    = 5'd8;
  localparam tok_type_t TOK_RBRACE    = 5'd9;
  localparam tok_type_t TOK_LBRACKET  = 5'd10;
  localparam tok_type_t TOK_RBRACKET  = 5'd11;
  localparam tok_type_t TOK_SEMICOLON = 5'd12;
  localparam tok_type_t TOK_LT        = 5'd13;
  localparam tok_type_t TOK_GT        = 5'd14;
  localparam tok_type_t TOK_STAR      = 5'd15;
  localparam tok_type_t TOK_UNKNOWN   = 5'd16;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_POUND      = 8'h23;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
  localparam logic [7:0] CH_LT         = 8'h3C;
  localparam logic [7:0] CH_GT         = 8'h3E;
  localparam logic [7:0] CH_LBRACKET   = 8'h5B;
  localparam logic [7:0] CH_RBRACKET   = 8'h5D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_F          = 8'h66;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;

  // result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = 2;

  // lexer modes, one-hot
  typedef enum logic [10:0] {
    M_IDLE       = 11'b000_0000_0001,
    M_SLASH      = 11'b000_0000_0010,
    M_LINE       = 11'b000_0000_0100,
    M_BLOCK      = 11'b000_0000_1000,
    M_BLOCK_STAR = 11'b000_0001_0000,
    M_STRING     = 11'b000_0010_0000,
    M_NUM_D      = 11'b000_0100_0000,
    M_NUM_S      = 11'b000_1000_0000,
    M_ID_A       = 11'b001_0000_0000,
    M_ID_U       = 11'b010_0000_0000,
    M_ID_D       = 11'b100_0000_0000
  } mode_t;

  // results of one byte: a flushed pending token (a) and a fresh one (b)
  typedef struct packed {
    logic      a_valid;
    tok_type_t a_type;
    logic      b_valid;
    tok_type_t b_type;
  } clx_emit_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic tok_type_t punct_type(input logic [7:0] c);
    tok_type_t t;
    unique case (c)
      CH_POUND:     t = TOK_POUND;
      CH_LPAREN:    t = TOK_LPAREN;
      CH_RPAREN:    t = TOK_RPAREN;
      CH_LBRACE:    t = TOK_LBRACE;
      CH_RBRACE:    t = TOK_RBRACE;
      CH_LBRACKET:  t = TOK_LBRACKET;
      CH_RBRACKET:  t = TOK_RBRACKET;
      CH_SEMICOLON: t = TOK_SEMICOLON;
      CH_LT:        t = TOK_LT;
      CH_GT:        t = TOK_GT;
      CH_STAR:      t = TOK_STAR;
      default:      t = TOK_UNKNOWN;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/c_source_lexer.sv
// top level of the c source lexer: byte stream in, token words out
//
// channel | handshake                | payload
// --------+--------------------------+--------------------------------------------------
// char    | char_valid / char_stall  | char_byte, end_of_input
// token   | token_valid / token_stall| token_kind, token_offset, token_length, last_of_item
//
// one source byte is taken per cycle while char_stall is low; the byte goes into an
// input register, the lexer decides its tokens from that register, and the token words
// are written into the result queue, whose head drives the outputs
// a byte that both ends a token and is a token itself, or an end of text with a pending
// token, gives two words; the four-entry result queue drains one word a cycle while
// token_stall is low, so the sustained rate is one byte per cycle while bytes average
// no more than one word each and the token side keeps up
// char_stall rises only when the input register holds a byte and the queue has fewer
// than two free entries
// rst (synchronous) returns the lexer to idle at stream position zero and empties both
// the input register and the queue
module c_source_lexer import clx_pkg::*; #(
  parameter int LENGTH_BITS   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     char_valid,
  output logic                     char_stall,
  input  logic [7:0]               char_byte,
  input  logic                     end_of_input,
  output logic                     token_valid,
  input  logic                     token_stall,
  output logic [4:0]               token_kind,
  output logic [POSITION_BITS-1:0] token_offset,
  output logic [LENGTH_BITS-1:0]   token_length,
  output logic                     last_of_item
);

  clx_emit_t                emit;
  logic                     room;
  logic [POSITION_BITS-1:0] a_offset;
  logic [LENGTH_BITS-1:0]   a_length;
  logic [POSITION_BITS-1:0] b_offset;

  // lexer state machine and per-byte decision
  clx_core #(
    .LENGTH_BITS   (LENGTH_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_byte    (char_byte),
    .end_of_input (end_of_input),
    .room         (room),
    .emit         (emit),
    .a_offset     (a_offset),
    .a_length     (a_length),
    .b_offset     (b_offset)
  );

  // token words in order, flushed token before the fresh one
  clx_fifo #(
    .LENGTH_BITS   (LENGTH_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_fifo (
    .clk          (clk),
    .rst          (rst),
    .emit         (emit),
    .a_offset     (a_offset),
    .a_length     (a_length),
    .b_offset     (b_offset),
    .room         (room),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token_kind   (token_kind),
    .token_offset (token_offset),
    .token_length (token_length),
    .last_of_item (last_of_item)
  );

endmodule

FILE: rtl/clx_core.sv
// input register, lexer state and per-byte token decision
module clx_core import clx_pkg::*; #(
  parameter int LENGTH_BITS   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     char_valid,
  output logic                     char_stall,
  input  logic [7:0]               char_byte,
  input  logic                     end_of_input,
  input  logic                     room,
  output clx_emit_t                emit,
  output logic [POSITION_BITS-1:0] a_offset,
  output logic [LENGTH_BITS-1:0]   a_length,
  output logic [POSITION_BITS-1:0] b_offset
);

  logic                     ivalid;
  logic [7:0]               ibyte;
  logic                     ieoi;
  logic                     fire;
  logic                     is_end;

  mode_t                    mode, mode_next;
  logic [LENGTH_BITS-1:0]   plen, plen_next, len_ext;
  logic [POSITION_BITS-1:0] pstart, pstart_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic                     path, path_next;
  logic                     flush_req, restart, pend_has;
  tok_type_t                pend_type;

  assign fire       = ivalid && room;
  assign char_stall = ivalid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else begin
      ivalid <= (char_valid && !char_stall) || (ivalid && !fire);
    end
    if (char_valid && !char_stall) begin
      ibyte <= char_byte;
      ieoi  <= end_of_input;
    end
  end

  always_comb begin
    pend_has  = 1'b1;
    pend_type = TOK_UNKNOWN;
    unique case (mode)
      M_SLASH:                 pend_type = TOK_UNKNOWN;
      M_STRING:                pend_type = TOK_STRING;
      M_NUM_D, M_NUM_S:        pend_type = TOK_NUMBER;
      M_ID_A, M_ID_U, M_ID_D:  pend_type = path ? TOK_PATH : TOK_IDENT;
      default:                 pend_has  = 1'b0;
    endcase
  end

  always_comb begin
    mode_next   = mode;
    plen_next   = plen;
    pstart_next = pstart;
    pos_next    = pos + POSITION_BITS'(1);
    path_next   = path;
    flush_req   = 1'b0;
    restart     = 1'b0;
    len_ext     = (plen == '1) ? plen : plen + LENGTH_BITS'(1);
    is_end      = ieoi || (ibyte == CH_NUL);
    emit        = '0;
    a_offset    = pstart;
    a_length    = plen;
    b_offset    = pos;

    if (!is_end) begin
      unique case (mode)
        M_LINE: begin
          if (ibyte == CH_NEWLINE) mode_next = M_IDLE;
        end
        M_BLOCK: begin
          if (ibyte == CH_STAR) mode_next = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          if (ibyte == CH_SLASH) mode_next = M_IDLE;
          else if (ibyte != CH_STAR) mode_next = M_BLOCK;
        end
        M_STRING: begin
          plen_next = len_ext;
          a_length  = len_ext;
          if (ibyte == CH_QUOTE) begin
            flush_req = 1'b1;
            mode_next = M_IDLE;
          end
        end
        M_SLASH: begin
          if (ibyte == CH_SLASH) mode_next = M_LINE;
          else if (ibyte == CH_STAR) mode_next = M_BLOCK;
          else begin
            flush_req = 1'b1;
            restart   = 1'b1;
          end
        end
        M_NUM_D: begin
          if (is_digit(ibyte)) plen_next = len_ext;
          else if (ibyte == CH_DOT || ibyte == CH_F) begin
            plen_next = len_ext;
            mode_next = M_NUM_S;
          end else begin
            flush_req = 1'b1;
            restart   = 1'b1;
          end
        end
        M_NUM_S: begin
          if (is_digit(ibyte)) begin
            plen_next = len_ext;
            mode_next = M_NUM_D;
          end else begin
            flush_req = 1'b1;
            restart   = 1'b1;
          end
        end
        M_ID_A, M_ID_U, M_ID_D: begin
          if (ibyte == CH_UNDERSCORE && mode == M_ID_A) begin
            plen_next = len_ext;
            mode_next = M_ID_U;
          end else if (ibyte == CH_DOT && mode != M_ID_D) begin
            plen_next = len_ext;
            path_next = 1'b1;
            mode_next = M_ID_D;
          end else if (is_digit(ibyte)) begin
            plen_next = len_ext;
            mode_next = M_ID_D;
          end else if (is_alpha(ibyte)) begin
            plen_next = len_ext;
            mode_next = M_ID_A;
          end else begin
            flush_req = 1'b1;
            restart   = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase

      // byte handled afresh: whitespace is skipped, any other byte starts a new token
      if (restart) begin
        mode_next = M_IDLE;
        if (is_space(ibyte)) begin
          mode_next = M_IDLE;
        end else if (ibyte == CH_SLASH || ibyte == CH_QUOTE || is_digit(ibyte) ||
                     is_alpha(ibyte)) begin
          pstart_next = pos;
          plen_next   = LENGTH_BITS'(1);
          if (ibyte == CH_SLASH) mode_next = M_SLASH;
          else if (ibyte == CH_QUOTE) mode_next = M_STRING;
          else if (is_digit(ibyte)) mode_next = M_NUM_D;
          else begin
            mode_next = M_ID_A;
            path_next = 1'b0;
          end
        end else begin
          emit.b_valid = 1'b1;
          emit.b_type  = punct_type(ibyte);
        end
      end
    end else begin
      // end of text: pending token, eof, then back to reset state
      flush_req    = 1'b1;
      emit.b_valid = 1'b1;
      emit.b_type  = TOK_EOF;
      mode_next    = M_IDLE;
      plen_next    = '0;
      pstart_next  = '0;
      pos_next     = '0;
      path_next    = 1'b0;
    end

    emit.a_valid = flush_req && pend_has && fire;
    emit.a_type  = pend_type;
    emit.b_valid = emit.b_valid && fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      plen   <= '0;
      pstart <= '0;
      pos    <= '0;
      path   <= 1'b0;
    end else if (fire) begin
      mode   <= mode_next;
      plen   <= plen_next;
      pstart <= pstart_next;
      pos    <= pos_next;
      path   <= path_next;
    end
  end

  // end of text always leaves the lexer at position zero between tokens
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    fire && is_end |=> (mode == M_IDLE) && (pos == '0) && !path)
    else $error("end of text did not reset lexer state");

  // a flushed token only comes from a mode that holds one
  a_flush_pending: assert property (@(posedge clk) disable iff (rst)
    emit.a_valid |-> (mode != M_IDLE) && (mode != M_LINE) && (mode != M_BLOCK) &&
                     (mode != M_BLOCK_STAR))
    else $error("flush from a mode with no pending token");

endmodule

FILE: rtl/clx_fifo.sv
// small result queue taking up to two tokens per cycle and giving one when not stalled
module clx_fifo import clx_pkg::*; #(
  parameter int LENGTH_BITS   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  clx_emit_t                emit,
  input  logic [POSITION_BITS-1:0] a_offset,
  input  logic [LENGTH_BITS-1:0]   a_length,
  input  logic [POSITION_BITS-1:0] b_offset,
  output logic                     room,
  output logic                     token_valid,
  input  logic                     token_stall,
  output logic [4:0]               token_kind,
  output logic [POSITION_BITS-1:0] token_offset,
  output logic [LENGTH_BITS-1:0]   token_length,
  output logic                     last_of_item
);

  tok_type_t                ent_type   [FIFO_DEPTH];
  logic [POSITION_BITS-1:0] ent_offset [FIFO_DEPTH];
  logic [LENGTH_BITS-1:0]   ent_length [FIFO_DEPTH];
  logic                     ent_last   [FIFO_DEPTH];

  logic [PTR_BITS-1:0] wptr, rptr, bptr;
  logic [PTR_BITS:0]   count, count_next;
  logic                pop;

  assign room         = count <= (PTR_BITS + 1)'(FIFO_DEPTH - 2);
  assign token_valid  = count != '0;
  assign pop          = token_valid && !token_stall;
  assign token_kind   = ent_type[rptr];
  assign token_offset = ent_offset[rptr];
  assign token_length = ent_length[rptr];
  assign last_of_item = ent_last[rptr];
  assign bptr         = wptr + PTR_BITS'(emit.a_valid);

  assign count_next = count + (PTR_BITS + 1)'(emit.a_valid) + (PTR_BITS + 1)'(emit.b_valid)
                      - (PTR_BITS + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= bptr + PTR_BITS'(emit.b_valid);
      rptr  <= rptr + PTR_BITS'(pop);
      count <= count_next;
    end
    if (emit.a_valid) begin
      ent_type[wptr]   <= emit.a_type;
      ent_offset[wptr] <= a_offset;
      ent_length[wptr] <= a_length;
      ent_last[wptr]   <= !emit.b_valid;
    end
    if (emit.b_valid) begin
      ent_type[bptr]   <= emit.b_type;
      ent_offset[bptr] <= b_offset;
      ent_length[bptr] <= (emit.b_type == TOK_EOF) ? '0 : LENGTH_BITS'(1);
      ent_last[bptr]   <= 1'b1;
    end
  end

  // pushes only arrive with room for two, so the queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_BITS + 1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (emit.a_valid || emit.b_valid) |-> $past(room) || room)
    else $error("push without room");

endmodule
